>>> design/tlbpc_pkg.sv
// ----------------------------------------------------------------------------
// tlbpc_pkg
// Shared types and constants for the tank level bar and pump control block.
// ----------------------------------------------------------------------------
package tlbpc_pkg;

  // Field widths
  localparam int unsigned ECHO_W  = 15;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned ONMAX_W = 4;
  localparam int unsigned PCT_W   = 7;
  localparam int unsigned BAR_W   = 4;
  localparam int unsigned LED_W   = 11;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CIDX_W  = 2;

  // Shared divider geometry
  localparam int unsigned DIV_W   = 24;  // dividend / quotient bits
  localparam int unsigned DVS_W   = 15;  // divisor bits
  localparam int unsigned ITER_W  = 5;

  // Per-operation dividend widths (iteration counts)
  localparam int unsigned PCT_ITERS  = 15;
  localparam int unsigned BAR_ITERS  = 7;

  // Echo to centimeters: echo * 343 / 20000
  localparam logic [DIV_W-1:0] SOUND_MUL = DIV_W'(343);
  localparam logic [DVS_W-1:0] SOUND_DIV = DVS_W'(20000);

  // Same scaling as one multiply: (echo * SOUND_RECIP) >> RECIP_SH,
  // exact for every 15-bit echo
  localparam int unsigned        RECIP_W     = 25;
  localparam int unsigned        RECIP_SH    = 30;
  localparam logic [RECIP_W-1:0] SOUND_RECIP = RECIP_W'(18414673);

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);
  localparam logic [BAR_W-1:0] BAR_FULL = BAR_W'(10);
  localparam logic [PCT_W-1:0] BAR_MAXQ = PCT_W'(9);

  // Register reset values
  localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(9);
  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(7);
  localparam logic [ONMAX_W-1:0] ONMAX_RST = ONMAX_W'(1);

  // Register indexes
  localparam logic [CIDX_W-1:0] CFG_DEPTH = CIDX_W'(0);
  localparam logic [CIDX_W-1:0] CFG_STEP  = CIDX_W'(1);
  localparam logic [CIDX_W-1:0] CFG_ONMAX = CIDX_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_SUM,
    ST_MEAN_ST,
    ST_MEAN,
    ST_PCT,
    ST_BAR_ST,
    ST_BAR,
    ST_OUT
  } state_e;

  // Request to the shared divider
  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;  // left-aligned to DIV_W
    logic [DVS_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  // LED bar pattern per bar index
  function automatic logic [LED_W-1:0] bar_pattern(input logic [BAR_W-1:0] bar);
    logic [LED_W-1:0] pat;
    case (bar)
      4'd0:    pat = 11'h100;
      4'd1:    pat = 11'h300;
      4'd2:    pat = 11'h700;
      4'd3:    pat = 11'h780;
      4'd4:    pat = 11'h7C0;
      4'd5:    pat = 11'h7E0;
      4'd6:    pat = 11'h7F0;
      4'd7:    pat = 11'h7F8;
      4'd8:    pat = 11'h7FC;
      4'd9:    pat = 11'h7FE;
      default: pat = 11'h7FF;
    endcase
    return pat;
  endfunction

endpackage

>>> design/tlbpc_div.sv
// ----------------------------------------------------------------------------
// tlbpc_div
// Shared restoring divider, one quotient bit per cycle, variable bit count.
// ----------------------------------------------------------------------------
module tlbpc_div
  import tlbpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  div_req_t         req_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quot_o
);

  logic [DIV_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q;
  logic [ITER_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [DVS_W:0]    trial;
  logic [DVS_W:0]    diff;
  logic              qbit;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    trial = {rem_q, dvd_q[DIV_W-1]};
    diff  = trial - {1'b0, dvs_q};
    qbit  = (trial >= {1'b0, dvs_q});
    rem_d = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    dvd_d = {dvd_q[DIV_W-2:0], qbit};
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = dvd_q;

endmodule

>>> design/tlbpc_ring.sv
// ----------------------------------------------------------------------------
// tlbpc_ring
// Ring of recent distances with write pointer and one indexed read port.
// ----------------------------------------------------------------------------
module tlbpc_ring
  import tlbpc_pkg::*;
#(
  parameter int unsigned SMOOTH_DEPTH = 5,
  parameter int unsigned IW = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic [DIST_W-1:0] wr_data_i,
  input  logic [IW-1:0]     rd_idx_i,
  output logic [DIST_W-1:0] rd_data_o
);

  localparam logic [IW-1:0] LAST = IW'(SMOOTH_DEPTH - 1);

  logic [DIST_W-1:0] ring_q [SMOOTH_DEPTH];
  logic [IW-1:0]     pos_q;

  // Write at pointer, then advance with wrap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        ring_q[i] <= '0;
      end
    end else if (wr_en_i) begin
      ring_q[pos_q] <= wr_data_i;
      pos_q         <= (pos_q == LAST) ? '0 : pos_q + IW'(1);
    end
  end

  assign rd_data_o = ring_q[rd_idx_i];

endmodule

>>> design/tank_level_bar_pump_control.sv
// ----------------------------------------------------------------------------
// tank_level_bar_pump_control
// Echo time to smoothed tank level, LED bar pattern and pump relay.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall_o is high from acceptance until the
// result has been loaded into the output register. The echo is scaled to
// centimeters by one constant multiply at acceptance; the mean, percent and
// bar divisions share one restoring divider that produces one quotient bit
// per cycle. The next item can be accepted in the cycle after the result is
// loaded; the load waits while the output register holds a stalled result.
// A stalled result in the output register holds back only the next result,
// not the next item. Configuration writes are always ready and take effect
// at once.
// ----------------------------------------------------------------------------
module tank_level_bar_pump_control
  import tlbpc_pkg::*;
#(
  parameter int unsigned SMOOTH_DEPTH = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input items
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ECHO_W-1:0]  echo_us_i,
  // result items
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LED_W-1:0]   led_pattern_o,
  output logic               relay_on_o,
  output logic [PCT_W-1:0]   level_percent_o,
  output logic [BAR_W-1:0]   bar_index_o,
  output logic               no_reading_o,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CIDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i
);

  localparam int unsigned IW    = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
  localparam int unsigned SUM_W = $clog2(SMOOTH_DEPTH * 1023 + 1);
  localparam int unsigned CNT_W = $clog2(SMOOTH_DEPTH + 1);
  localparam int unsigned PROD_W = ECHO_W + RECIP_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(SMOOTH_DEPTH - 1);

  state_e state_q, state_d;

  // Configuration registers
  logic [DEPTH_W-1:0] depth_q;
  logic [STEP_W-1:0]  step_q;
  logic [ONMAX_W-1:0] onmax_q;
  logic [DEPTH_W-1:0] depth_eff;
  logic [STEP_W-1:0]  step_eff;

  // Work registers
  logic [SUM_W-1:0] sum_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IW-1:0]    idx_q;
  logic [PCT_W-1:0] pct_q;
  logic             none_q;
  logic             relay_q;
  logic [DIST_W-1:0] echo_cm_q;

  // Output register
  logic             out_valid_q;
  logic [LED_W-1:0] led_q;
  logic             relay_out_q;
  logic [PCT_W-1:0] pct_out_q;
  logic [BAR_W-1:0] bar_out_q;
  logic             none_out_q;
  logic [BAR_W-1:0] bar_res_q;

  // Submodule wiring
  div_req_t          div_req;
  logic              div_done;
  logic [DIV_W-1:0]  div_quot;
  logic              ring_wr;
  logic [DIST_W-1:0] ring_rd;

  logic              in_acc;
  logic              out_free;
  logic [PROD_W-1:0] echo_prod;
  logic [DIST_W-1:0] mean_cm;
  logic              dist_full;
  logic [DEPTH_W-1:0] diff;
  logic [PCT_W+DEPTH_W:0] diff_x100;
  logic [BAR_W-1:0]  bar_calc;

  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign depth_eff = (depth_q == '0) ? DEPTH_W'(1) : depth_q;
  assign step_eff  = (step_q == '0) ? STEP_W'(1) : step_q;

  // Echo to centimeters by reciprocal multiply
  assign echo_prod = PROD_W'(echo_us_i) * PROD_W'(SOUND_RECIP);

  // Mean distance and percent numerator
  assign mean_cm   = div_quot[DIST_W-1:0];
  assign dist_full = ({2'b00, depth_eff} <= mean_cm);
  assign diff      = depth_eff - mean_cm[DEPTH_W-1:0];
  assign diff_x100 = (PCT_W+DEPTH_W+1)'(diff) * (PCT_W+DEPTH_W+1)'(PCT_FULL);
  assign bar_calc  = (div_quot[PCT_W-1:0] > BAR_MAXQ) ? BAR_FULL
                                                      : div_quot[BAR_W-1:0];

  tlbpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  tlbpc_ring #(
    .SMOOTH_DEPTH (SMOOTH_DEPTH),
    .IW           (IW)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (ring_wr),
    .wr_data_i (echo_cm_q),
    .rd_idx_i  (idx_q),
    .rd_data_o (ring_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (echo_us_i == '0) ? ST_BAR_ST : ST_DIST;
        end
      end
      ST_DIST:    state_d = ST_SUM;
      ST_SUM:     if (idx_q == LAST_IDX) state_d = ST_MEAN_ST;
      ST_MEAN_ST: state_d = (cnt_q == '0) ? ST_BAR_ST : ST_MEAN;
      ST_MEAN: begin
        if (div_done) state_d = dist_full ? ST_BAR_ST : ST_PCT;
      end
      ST_PCT:     if (div_done) state_d = ST_BAR_ST;
      ST_BAR_ST:  state_d = ST_BAR;
      ST_BAR:     if (div_done) state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider requests and ring write
  always_comb begin
    div_req  = '0;
    ring_wr  = 1'b0;
    unique case (state_q)
      ST_DIST: ring_wr = 1'b1;
      ST_MEAN_ST: begin
        div_req.start    = (cnt_q != '0);
        div_req.dividend = DIV_W'(sum_q) << (DIV_W - SUM_W);
        div_req.divisor  = DVS_W'(cnt_q);
        div_req.iters    = ITER_W'(SUM_W);
      end
      ST_MEAN: begin
        div_req.start    = div_done && !dist_full;
        div_req.dividend = DIV_W'(diff_x100) << (DIV_W - PCT_ITERS);
        div_req.divisor  = DVS_W'(depth_eff);
        div_req.iters    = ITER_W'(PCT_ITERS);
      end
      ST_BAR_ST: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(pct_q) << (DIV_W - BAR_ITERS);
        div_req.divisor  = DVS_W'(step_eff);
        div_req.iters    = ITER_W'(BAR_ITERS);
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      relay_q     <= 1'b0;
      depth_q     <= DEPTH_RST;
      step_q      <= STEP_RST;
      onmax_q     <= ONMAX_RST;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // relay hysteresis
      if (state_q == ST_BAR && div_done) begin
        if (bar_calc == BAR_FULL) begin
          relay_q <= 1'b0;
        end else if (bar_calc <= onmax_q) begin
          relay_q <= 1'b1;
        end
      end
      // configuration decode
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_DEPTH: depth_q <= cfg_data_i[DEPTH_W-1:0];
          CFG_STEP:  step_q  <= cfg_data_i[STEP_W-1:0];
          CFG_ONMAX: onmax_q <= cfg_data_i[ONMAX_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Work datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          none_q    <= (echo_us_i == '0);
          pct_q     <= PCT_FULL;
          echo_cm_q <= echo_prod[RECIP_SH +: DIST_W];
        end
      end
      ST_DIST: begin
        idx_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end
      ST_SUM: begin
        if (ring_rd != '0) begin
          sum_q <= sum_q + SUM_W'(ring_rd);
          cnt_q <= cnt_q + CNT_W'(1);
        end
        if (idx_q != LAST_IDX) begin
          idx_q <= idx_q + IW'(1);
        end
      end
      ST_MEAN_ST: begin
        if (cnt_q == '0) begin
          none_q <= 1'b1;
          pct_q  <= PCT_FULL;
        end
      end
      ST_MEAN: begin
        if (div_done && dist_full) begin
          pct_q <= '0;
        end
      end
      ST_PCT: begin
        if (div_done) begin
          pct_q <= (div_quot > DIV_W'(PCT_FULL)) ? PCT_FULL : div_quot[PCT_W-1:0];
        end
      end
      ST_BAR: begin
        if (div_done) begin
          bar_res_q <= bar_calc;
        end
      end
      default: ;
    endcase
  end

  // Output register load
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      led_q       <= bar_pattern(bar_res_q);
      relay_out_q <= relay_q;
      pct_out_q   <= pct_q;
      bar_out_q   <= bar_res_q;
      none_out_q  <= none_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign led_pattern_o   = led_q;
  assign relay_on_o      = relay_out_q;
  assign level_percent_o = pct_out_q;
  assign bar_index_o     = bar_out_q;
  assign no_reading_o    = none_out_q;

endmodule

>>> tb/sv/tank_level_bar_pump_control_test.sv
// ----------------------------------------------------------------------------
// tank_level_bar_pump_control_test
// Self-checking bench for the echo-to-level, LED bar and pump relay block.
// A short table of directed items and register writes runs first. A few
// expected results are typed into the table; all others come from a local
// level predictor. Randomized blocks follow, with level sweeps and noise,
// under three patterns of sender idling and receiver stall.
// ----------------------------------------------------------------------------
module tank_level_bar_pump_control_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tlbpc_pkg::*;

  localparam int unsigned RING_N = 5;
  localparam logic [CIDX_W-1:0] CFG_UNUSED = CIDX_W'(3);
  localparam logic [LED_W-1:0] LED_TABLE [11] = '{
    11'h100, 11'h300, 11'h700, 11'h780, 11'h7C0, 11'h7E0,
    11'h7F0, 11'h7F8, 11'h7FC, 11'h7FE, 11'h7FF
  };

  typedef struct packed {
    logic [LED_W-1:0] led;
    logic             relay;
    logic [PCT_W-1:0] pct;
    logic [BAR_W-1:0] bar;
    logic             none;
  } level_t;

  typedef struct {
    logic              is_cfg;
    logic [CIDX_W-1:0] idx;
    logic [CFG_W-1:0]  data;
    logic [ECHO_W-1:0] echo;
    logic              typed;
    level_t            want;
  } stim_row_t;

  // DUT signals, all inputs known from time zero
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ECHO_W-1:0]  echo_us_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LED_W-1:0]   led_pattern_o;
  logic               relay_on_o;
  logic [PCT_W-1:0]   level_percent_o;
  logic [BAR_W-1:0]   bar_index_o;
  logic               no_reading_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CIDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;

  // Idling controls
  int unsigned in_idle_pct = 13;
  int unsigned out_stall_pct = 50;

  // Expected results in order, and failure count
  level_t level_q[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;

  // Predictor state and registers
  logic [DIST_W-1:0]  ring_q [RING_N];
  int unsigned        ring_pos;
  logic               relay_q;
  logic [DEPTH_W-1:0] depth_q;
  logic [STEP_W-1:0]  step_q;
  logic [ONMAX_W-1:0] onmax_q;

  stim_row_t directed_q[$];

  tank_level_bar_pump_control #(
    .SMOOTH_DEPTH(RING_N)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .echo_us_i      (echo_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .led_pattern_o  (led_pattern_o),
    .relay_on_o     (relay_on_o),
    .level_percent_o(level_percent_o),
    .bar_index_o    (bar_index_o),
    .no_reading_o   (no_reading_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Run limit
  initial begin
    #20_000_000;
    $display("tank_level_bar_pump_control: mismatch");
    $finish;
  end

  // Level predictor: ring update, smoothed distance, percent, bar, relay
  function automatic level_t predict_level(input logic [ECHO_W-1:0] echo);
    int unsigned depth, step, mean_cm, sum, cnt, pct, bar, i;
    logic none;
    level_t r;
    depth = (depth_q == 0) ? 1 : int'(depth_q);
    step  = (step_q == 0) ? 1 : int'(step_q);
    none  = 1'b1;
    mean_cm = 0;
    if (echo != 0) begin
      ring_q[ring_pos] = DIST_W'((32'(echo) * 32'(SOUND_MUL)) / 32'(SOUND_DIV));
      ring_pos = (ring_pos + 1) % RING_N;
      sum = 0;
      cnt = 0;
      for (i = 0; i < RING_N; i++) begin
        if (ring_q[i] != 0) begin
          sum += ring_q[i];
          cnt++;
        end
      end
      if (cnt != 0) begin
        none = 1'b0;
        mean_cm = sum / cnt;
      end
    end
    if (none) pct = 100;
    else if (mean_cm >= depth) pct = 0;
    else pct = ((depth - mean_cm) * 100) / depth;
    if (pct > 100) pct = 100;
    bar = pct / step;
    if (bar > 9) bar = 10;
    if (bar == 10) relay_q = 1'b0;
    else if (bar <= onmax_q) relay_q = 1'b1;
    r.led   = LED_TABLE[bar];
    r.relay = relay_q;
    r.pct   = PCT_W'(pct);
    r.bar   = BAR_W'(bar);
    r.none  = none;
    return r;
  endfunction

  // Random echo: mostly a triangle sweep of the level, some noise
  function automatic logic [ECHO_W-1:0] pick_echo(input int unsigned k);
    int unsigned depth, tri_pos, base;
    depth = (depth_q == 0) ? 1 : int'(depth_q);
    tri_pos = k % 40;
    if (tri_pos > 20) tri_pos = 40 - tri_pos;
    base = (depth * tri_pos * 20000) / (20 * 343);
    case ($urandom_range(19))
      0:       return '0;
      1:       return ECHO_W'($urandom_range(1, 58));
      2, 3:    return ECHO_W'($urandom());
      4, 5:    return ECHO_W'($urandom_range(0, depth * 62 + 60));
      default: return ECHO_W'(base + $urandom_range(0, 60));
    endcase
  endfunction

  // Register write, only with nothing in flight
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEPTH: depth_q = data;
      CFG_STEP:  step_q  = data[STEP_W-1:0];
      CFG_ONMAX: onmax_q = data[ONMAX_W-1:0];
      default:   ;
    endcase
    @(posedge clk_i);
  endtask

  // One echo item; typed expectation overrides the predictor output
  task automatic send_echo(input logic [ECHO_W-1:0] echo, input logic typed,
                           input level_t want);
    level_t pred;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    echo_us_i  <= echo;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_level(echo);
    level_q.push_back(typed ? want : pred);
  endtask

  task automatic add_item(input logic [ECHO_W-1:0] echo);
    directed_q.push_back('{1'b0, CFG_DEPTH, '0, echo, 1'b0, '0});
  endtask

  task automatic add_typed(input logic [ECHO_W-1:0] echo, input level_t want);
    directed_q.push_back('{1'b0, CFG_DEPTH, '0, echo, 1'b1, want});
  endtask

  task automatic add_cfg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    directed_q.push_back('{1'b1, idx, data, '0, 1'b0, '0});
  endtask

  // Receiver stall
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_stall_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin : check_results
    level_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{led_pattern_o, relay_on_o, level_percent_o, bar_index_o, no_reading_o};
      results_seen++;
      if (level_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: none expected, got led=%h relay=%b pct=%0d bar=%0d none=%b",
                   results_seen, got.led, got.relay, got.pct, got.bar, got.none);
      end else begin
        want = level_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected led=%h relay=%b pct=%0d bar=%0d none=%b,",
                      " got led=%h relay=%b pct=%0d bar=%0d none=%b"}, results_seen,
                     want.led, want.relay, want.pct, want.bar, want.none,
                     got.led, got.relay, got.pct, got.bar, got.none);
        end
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    int unsigned phase, blk, k, i;
    for (i = 0; i < RING_N; i++) ring_q[i] = '0;
    ring_pos = 0;
    relay_q  = 1'b0;
    depth_q  = DEPTH_RST;
    step_q   = STEP_RST;
    onmax_q  = ONMAX_RST;

    // Directed table: reset values, extremes, then register corner cases
    add_typed(15'd0,     '{11'h7FF, 1'b0, 7'd100, 4'd10, 1'b1});  // timeout
    add_typed(15'd1,     '{11'h7FF, 1'b0, 7'd100, 4'd10, 1'b1});  // zero distance only
    add_typed(15'd30000, '{11'h100, 1'b1, 7'd0,   4'd0,  1'b0});
    add_typed(15'h7FFF,  '{11'h100, 1'b1, 7'd0,   4'd0,  1'b0});
    add_typed(15'd0,     '{11'h7FF, 1'b0, 7'd100, 4'd10, 1'b1});  // ring kept
    add_cfg(CFG_DEPTH, 8'd255);
    add_item(15'd5000);
    add_item(15'h5555);
    add_item(15'h2AAA);
    add_cfg(CFG_STEP, 8'd0);        // step zero acts as one
    add_item(15'd2000);
    add_cfg(CFG_ONMAX, 8'hFF);      // wide write, on-threshold 15
    add_item(15'd9000);
    add_cfg(CFG_DEPTH, 8'd0);       // depth zero acts as one
    add_item(15'd100);
    add_cfg(CFG_STEP, 8'hFF);       // wide write, step 127
    add_item(15'd0);
    add_cfg(CFG_UNUSED, 8'hA5);     // ignored
    add_cfg(CFG_DEPTH, 8'd60);
    add_cfg(CFG_STEP, 8'd10);
    add_cfg(CFG_ONMAX, 8'd0);
    for (i = 0; i < RING_N; i++) add_item(15'd1);  // ring drains to no positive entry
    add_item(15'd1500);
    add_cfg(CFG_STEP, 8'd100);
    add_cfg(CFG_ONMAX, 8'd9);
    add_cfg(CFG_DEPTH, 8'd1);
    add_item(15'd58);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[r]) begin
      if (directed_q[r].is_cfg) write_reg(directed_q[r].idx, directed_q[r].data);
      else send_echo(directed_q[r].echo, directed_q[r].typed, directed_q[r].want);
    end

    // Random blocks under three idling patterns
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin in_idle_pct = 13; out_stall_pct = 50; end
        1:       begin in_idle_pct = 50; out_stall_pct = 13; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (blk = 0; blk < 6; blk++) begin
        case ($urandom_range(9))
          0:       write_reg(CFG_DEPTH, 8'd0);
          1:       write_reg(CFG_DEPTH, 8'd255);
          2:       write_reg(CFG_DEPTH, 8'd1);
          default: write_reg(CFG_DEPTH, CFG_W'($urandom_range(2, 255)));
        endcase
        case ($urandom_range(9))
          0:       write_reg(CFG_STEP, 8'd0);
          1:       write_reg(CFG_STEP, 8'd100);
          2:       write_reg(CFG_STEP, 8'hFF);
          default: write_reg(CFG_STEP, {1'($urandom_range(1)), 7'($urandom_range(1, 20))});
        endcase
        write_reg(CFG_ONMAX, {4'($urandom_range(15)), 4'($urandom_range(15))});
        if ($urandom_range(3) == 0) write_reg(CFG_UNUSED, CFG_W'($urandom()));
        for (k = 0; k < 105; k++) send_echo(pick_echo(k), 1'b0, '0);
      end
    end

    // Drain, then watch for stray results
    in_valid_i <= 1'b0;
    while (level_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tank_level_bar_pump_control: match");
    end else begin
      $display("tank_level_bar_pump_control: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
design/tlbpc_pkg.sv
design/tlbpc_div.sv
design/tlbpc_ring.sv
design/tank_level_bar_pump_control.sv
tb/sv/tank_level_bar_pump_control_test.sv
